### hw/rtl/cnu_pkg.sv
// shared types, constants and permutation tables for the cramer newton update block
package cnu_pkg;

    // request payload: one row of the system
    typedef struct packed {
        logic signed [31:0] jacobian_a;
        logic signed [31:0] jacobian_b;
        logic signed [31:0] jacobian_d;
        logic signed [31:0] residual;
        logic signed [31:0] concentration;
    } t_req;

    // result payload: one updated unknown
    typedef struct packed {
        logic signed [31:0] new_concentration;
        logic               singular;
        logic               last_of_run;
    } t_res;

    // determinant accumulator width
    localparam int WW = 128;
    // fraction bits of Q7.24
    localparam int FRAC = 24;
    // quotient bits kept; larger quotients clamp
    localparam int QW = 35;
    localparam logic [QW-1:0] QCLAMP = QW'(35'h4_0000_0000);

    // column per row for each permutation, row r at bits [2r+1:2r]
    localparam logic [5:0] PERM3 [6] = '{
        6'b10_01_00, 6'b01_10_00, 6'b10_00_01,
        6'b00_10_01, 6'b01_00_10, 6'b00_01_10
    };
    localparam logic [5:0] NEG3 = 6'b100110;
    localparam logic [5:0] PERM2 [2] = '{6'b00_01_00, 6'b00_00_01};
    localparam logic [1:0] NEG2 = 2'b10;

    // column taken by row r in permutation p
    function automatic logic [1:0] perm_col(logic dim3, logic [2:0] p, logic [1:0] r);
        logic [5:0] w;
        begin
            w = dim3 ? PERM3[p] : PERM2[p[0]];
            return w[2*r +: 2];
        end
    endfunction

    // odd permutation: term is subtracted
    function automatic logic perm_neg(logic dim3, logic [2:0] p);
        begin
            return dim3 ? NEG3[p] : NEG2[p[0]];
        end
    endfunction

endpackage

### hw/rtl/cramer_newton_update_3x3.sv
// one newton update of a small linear system by cramer's rule, shared multiplier and divider
// solve: rows 0..DIM-2 are only stored; after the last row the block computes DIM+1
//   determinants (just the first when it is zero) of NTERM terms, each term fetching its
//   DIM factors over the single row read port and then multiplying and accumulating, then a
//   35-bit restoring divide per unknown unless the quotient clamps. results come one per strobe, one cycle each.
// throughput: one request per cycle until the last row, then busy for the whole solve.
// reset: synchronous active low; clears the row counter, the sequencer and the strobe.
module cramer_newton_update_3x3 #(
    parameter int DIM = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  cnu_pkg::t_req   i_req,
    output logic            o_busy,
    output logic            o_strobe,
    output cnu_pkg::t_res   o_result
);

    localparam int AW    = (DIM > 2) ? 2 : 1;
    localparam int NTERM = (DIM > 2) ? 6 : 2;
    localparam logic DIM3 = (DIM > 2);

    typedef enum logic [3:0] {
        S_IDLE, S_F0, S_F1, S_M0, S_M1, S_ADD, S_DET, S_DCHK, S_DIV, S_PRE, S_OUT
    } t_state;

    t_state                 r_state;
    logic [AW-1:0]          r_row;
    logic [AW-1:0]          r_fr;
    logic [1:0]             r_m;
    logic [2:0]             r_p;
    logic signed [31:0]     r_fac [DIM];
    logic signed [64:0]     r_mul;
    logic [31:0]            r_hi;
    logic                   r_sh;
    logic                   r_last;
    logic [cnu_pkg::WW-1:0] r_acc;
    logic [cnu_pkg::WW-1:0] r_dm;
    logic                   r_dneg;
    logic                   r_nneg;
    logic                   r_sing;
    logic [cnu_pkg::WW-1:0] r_rem;
    logic [cnu_pkg::QW-1:0] r_lo;
    logic [cnu_pkg::QW-1:0] r_q;
    logic [5:0]             r_cnt;
    cnu_pkg::t_req          r_mem [DIM];
    cnu_pkg::t_req          r_rd;

    logic                   accept;
    logic [AW-1:0]          rd_addr;
    logic [1:0]             col;
    logic signed [31:0]     elem;
    logic signed [32:0]     mul_a;
    logic signed [31:0]     mul_b;
    logic [cnu_pkg::WW-1:0] addend;
    logic [cnu_pkg::WW-1:0] acc_abs;
    logic [cnu_pkg::WW-1:0] num;
    logic [cnu_pkg::WW-1:0] trial;
    logic                   ge;
    logic [cnu_pkg::QW-1:0] qm;
    logic signed [35:0]     step;
    logic signed [36:0]     diff;
    logic signed [31:0]     sat;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // row store, one row written per request, one row read per cycle
    assign rd_addr = (r_state == S_F0) ? r_fr : r_m[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_row] <= i_req;
        end
        r_rd <= r_mem[rd_addr];
    end

    // element of the current permutation term, residual replaces column m
    always_comb begin
        col = cnu_pkg::perm_col(DIM3, r_p, 2'(r_fr));
        if (col == r_m) begin
            elem = r_rd.residual;
        end else begin
            unique case (col)
                2'd0:    elem = r_rd.jacobian_a;
                2'd1:    elem = r_rd.jacobian_b;
                default: elem = r_rd.jacobian_d;
            endcase
        end
    end

    // shared 33x32 multiplier operands
    always_comb begin
        unique case (r_state)
            S_M0:    mul_a = {r_fac[0][31], r_fac[0]};
            S_M1:    mul_a = {1'b0, r_mul[31:0]};
            default: mul_a = {r_hi[31], r_hi};
        endcase
        mul_b = (r_state == S_M0) ? r_fac[1] : r_fac[DIM-1];
    end

    // accumulator addend, high partial product shifted by one word
    assign addend = r_sh ? {{31{r_mul[64]}}, r_mul, 32'b0} : {{63{r_mul[64]}}, r_mul};

    // magnitude and scaled numerator
    assign acc_abs = r_acc[cnu_pkg::WW-1] ? (~r_acc + 1'b1) : r_acc;
    assign num     = {acc_abs[cnu_pkg::WW-cnu_pkg::FRAC-1:0], {cnu_pkg::FRAC{1'b0}}};

    // restoring divide step
    assign trial = {r_rem[cnu_pkg::WW-2:0], r_lo[cnu_pkg::QW-1]};
    assign ge    = (trial >= r_dm);

    // step and saturated update
    always_comb begin
        qm   = (r_q > cnu_pkg::QCLAMP) ? cnu_pkg::QCLAMP : r_q;
        step = (r_nneg ^ r_dneg) ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        diff = 37'(r_rd.concentration) - 37'(step);
        if (diff > 37'sd2147483647) begin
            sat = 32'sh7fff_ffff;
        end else if (diff < -37'sd2147483648) begin
            sat = 32'sh8000_0000;
        end else begin
            sat = diff[31:0];
        end
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_row    <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_row == AW'(DIM-1)) begin
                            r_row   <= '0;
                            r_m     <= 2'(DIM);
                            r_p     <= '0;
                            r_fr    <= '0;
                            r_acc   <= '0;
                            r_state <= S_F0;
                        end else begin
                            r_row <= r_row + 1'b1;
                        end
                    end
                end
                S_F0: begin
                    r_state <= S_F1;
                end
                S_F1: begin
                    r_fac[r_fr] <= elem;
                    if (r_fr == AW'(DIM-1)) begin
                        r_fr    <= '0;
                        r_state <= S_M0;
                    end else begin
                        r_fr    <= r_fr + 1'b1;
                        r_state <= S_F0;
                    end
                end
                S_M0: begin
                    r_mul  <= mul_a * mul_b;
                    r_sh   <= 1'b0;
                    r_last <= !DIM3;
                    r_state <= DIM3 ? S_M1 : S_ADD;
                end
                S_M1: begin
                    r_hi    <= r_mul[63:32];
                    r_mul   <= mul_a * mul_b;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc <= cnu_pkg::perm_neg(DIM3, r_p) ? (r_acc - addend) : (r_acc + addend);
                    if (!r_last) begin
                        r_mul  <= mul_a * mul_b;
                        r_sh   <= 1'b1;
                        r_last <= 1'b1;
                    end else if (r_p == 3'(NTERM-1)) begin
                        r_state <= S_DET;
                    end else begin
                        r_p     <= r_p + 1'b1;
                        r_state <= S_F0;
                    end
                end
                S_DET: begin
                    if (r_m == 2'(DIM)) begin
                        r_dm   <= acc_abs;
                        r_dneg <= r_acc[cnu_pkg::WW-1];
                        r_sing <= (r_acc == '0);
                        r_m    <= '0;
                        r_p    <= '0;
                        r_acc  <= '0;
                        r_state <= (r_acc == '0) ? S_PRE : S_F0;
                    end else begin
                        r_state <= S_DCHK;
                    end
                end
                S_DCHK: begin
                    r_nneg <= r_acc[cnu_pkg::WW-1];
                    r_cnt  <= 6'(cnu_pkg::QW-1);
                    if ({{cnu_pkg::QW{1'b0}}, num[cnu_pkg::WW-1:cnu_pkg::QW]} >= r_dm) begin
                        r_q     <= cnu_pkg::QCLAMP;
                        r_state <= S_OUT;
                    end else begin
                        r_rem   <= {{cnu_pkg::QW{1'b0}}, num[cnu_pkg::WW-1:cnu_pkg::QW]};
                        r_lo    <= num[cnu_pkg::QW-1:0];
                        r_q     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? (trial - r_dm) : trial;
                    r_q   <= {r_q[cnu_pkg::QW-2:0], ge};
                    r_lo  <= {r_lo[cnu_pkg::QW-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_PRE: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_strobe                   <= 1'b1;
                    o_result.new_concentration <= r_sing ? r_rd.concentration : sat;
                    o_result.singular          <= r_sing;
                    o_result.last_of_run       <= (r_m == 2'(DIM-1));
                    if (r_m == 2'(DIM-1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_m   <= r_m + 1'b1;
                        r_p   <= '0;
                        r_fr  <= '0;
                        r_acc <= '0;
                        r_state <= r_sing ? S_PRE : S_F0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // an accepted request never produces a result in the following cycle
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> !o_strobe)
        else $error("result strobe right after a request");

    // the divider only runs against a nonzero determinant
    a_div_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dm != '0))
        else $error("divide by zero determinant");

    // after the final result of a run the block is ready again
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last_of_run) |-> !o_busy)
        else $error("busy after last result");

endmodule

### dv/cramer_newton_update_3x3_tb.sv
// testbench for the cramer newton update block: directed and random row requests checked against a predictor
module cramer_newton_update_3x3_tb;

    localparam int  ONE_Q24   = 1 << 24;
    localparam int  TAIL_CYC  = 500;
    localparam int  LIMIT_CYC = 400000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_start;
    cnu_pkg::t_req  i_req;
    logic           o_busy;
    logic           o_strobe;
    cnu_pkg::t_res  o_result;

    cramer_newton_update_3x3 uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // rows waiting to be sent, with the sender idle rate and a drain flag per row
    cnu_pkg::t_req row_queue[$];
    int            idle_pct_queue[$];
    bit            drain_queue[$];
    // updated unknowns still to come out
    cnu_pkg::t_res update_queue[$];

    // predictor copy of the stored system
    logic signed [31:0] jac_rows[9];
    logic signed [31:0] res_rows[3];
    logic signed [31:0] conc_rows[3];
    int   next_row;

    int   errors;
    int   cycles;

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // report one mismatch and count it
    task automatic report(input string msg);
        begin
            $display("ERROR at cycle %0d: %s", cycles, msg);
            errors++;
        end
    endtask

    // determinant of the stored jacobian, column rep replaced by the residuals (rep 3: none)
    function automatic logic signed [127:0] det_with(input int rep);
        logic signed [127:0] e[9];
        begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    e[r*3+c] = (c == rep) ? res_rows[r] : jac_rows[r*3+c];
                end
            end
            return e[0] * (e[4] * e[8] - e[5] * e[7])
                 - e[1] * (e[3] * e[8] - e[5] * e[6])
                 + e[2] * (e[3] * e[7] - e[4] * e[6]);
        end
    endfunction

    // store one row; on the last row push the three updated unknowns
    task automatic predict_update(input cnu_pkg::t_req req);
        logic signed [127:0] d;
        logic signed [127:0] dj;
        logic signed [127:0] q;
        logic signed [127:0] upd;
        cnu_pkg::t_res r;
        begin
            jac_rows[next_row*3+0] = req.jacobian_a;
            jac_rows[next_row*3+1] = req.jacobian_b;
            jac_rows[next_row*3+2] = req.jacobian_d;
            res_rows[next_row]     = req.residual;
            conc_rows[next_row]    = req.concentration;
            if (next_row < 2) begin
                next_row++;
            end else begin
                next_row = 0;
                d = det_with(3);
                for (int j = 0; j < 3; j++) begin
                    upd = conc_rows[j];
                    if (d != 0) begin
                        dj = det_with(j);
                        q  = (dj <<< cnu_pkg::FRAC) / d;
                        if (q > (128'sd1 <<< 34)) q = 128'sd1 <<< 34;
                        if (q < -(128'sd1 <<< 34)) q = -(128'sd1 <<< 34);
                        upd = upd - q;
                        if (upd > 128'sd2147483647) upd = 128'sd2147483647;
                        if (upd < -128'sd2147483648) upd = -128'sd2147483648;
                    end
                    r.new_concentration = upd[31:0];
                    r.singular          = (d == 0);
                    r.last_of_run       = (j == 2);
                    update_queue.push_back(r);
                end
            end
        end
    endtask

    // driver: next row goes out once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) predict_update(i_req);
            if (!i_start || !o_busy) begin
                if (row_queue.size() != 0
                    && !(drain_queue[0] && (update_queue.size() != 0
                         || (i_start && !o_busy)))
                    && $urandom_range(99) >= idle_pct_queue[0]) begin
                    i_req   <= row_queue.pop_front();
                    void'(idle_pct_queue.pop_front());
                    void'(drain_queue.pop_front());
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe checked against the oldest expected update
    always @(posedge i_clk) begin
        cnu_pkg::t_res want;
        if (i_rst_n && o_strobe) begin
            if (update_queue.size() == 0) begin
                report("result with no expected update");
            end else begin
                want = update_queue.pop_front();
                if (o_result.new_concentration !== want.new_concentration)
                    report($sformatf("new_concentration %h, expected %h",
                           o_result.new_concentration, want.new_concentration));
                if (o_result.singular !== want.singular)
                    report($sformatf("singular %b, expected %b",
                           o_result.singular, want.singular));
                if (o_result.last_of_run !== want.last_of_run)
                    report($sformatf("last_of_run %b, expected %b",
                           o_result.last_of_run, want.last_of_run));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYC) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // queue one row
    task automatic add_row(input int a, input int b, input int d, input int res, input int conc,
                           input int pct, input bit drain);
        cnu_pkg::t_req r;
        begin
            r.jacobian_a    = a;
            r.jacobian_b    = b;
            r.jacobian_d    = d;
            r.residual      = res;
            r.concentration = conc;
            row_queue.push_back(r);
            idle_pct_queue.push_back(pct);
            drain_queue.push_back(drain);
        end
    endtask

    // random field: mostly moderate values near the Q7.24 unit, some full range
    function automatic int rand_val();
        begin
            case ($urandom_range(3))
                0: return $urandom;
                1: return int'($urandom_range(2 * ONE_Q24)) - ONE_Q24;
                default: return int'($urandom_range(16 * ONE_Q24)) - 8 * ONE_Q24;
            endcase
        end
    endfunction

    // random system of three rows; sometimes a repeated row forces a singular matrix
    task automatic add_system(input int pct, input bit drain);
        int a;
        int b;
        int d;
        bit dup;
        begin
            dup = ($urandom_range(9) == 0);
            a = rand_val();
            b = rand_val();
            d = rand_val();
            add_row(a, b, d, rand_val(), rand_val(), pct, drain);
            add_row(rand_val(), rand_val(), rand_val(), rand_val(), rand_val(), pct, 1'b0);
            if (dup) add_row(a, b, d, rand_val(), rand_val(), pct, 1'b0);
            else     add_row(rand_val(), rand_val(), rand_val(), rand_val(), rand_val(), pct,
                             1'b0);
        end
    endtask

    // stimulus and end of run
    initial begin
        int pct;
        errors    = 0;
        cycles    = 0;
        next_row  = 0;
        i_rst_n   = 1'b0;
        i_start   = 1'b0;
        i_req     = '0;

        // all-zero jacobian: singular, unknowns pass through at the extremes
        add_row(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 1'b0);
        add_row(0, 0, 0, 32'h80000000, 32'h80000000, 0, 1'b0);
        add_row(0, 0, 0, 0, 0, 0, 1'b0);
        // identity: step equals residual, saturating both ways
        add_row(ONE_Q24, 0, 0, 32'h80000000, 32'h7fffffff, 0, 1'b0);
        add_row(0, ONE_Q24, 0, 32'h7fffffff, 32'h80000000, 0, 1'b0);
        add_row(0, 0, ONE_Q24, ONE_Q24, 5 * ONE_Q24, 0, 1'b0);
        // negative diagonal, tiny determinant: step clamps
        add_row(-1, 0, 0, 32'h7fffffff, 0, 0, 1'b1);
        add_row(0, 1, 0, 32'h80000000, 32'h7fffffff, 0, 1'b0);
        add_row(0, 0, 1, 12345, 32'h80000000, 0, 1'b0);
        // extreme entries with a nonzero determinant
        add_row(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, -ONE_Q24, 0, 1'b0);
        add_row(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, ONE_Q24, 0, 1'b0);
        add_row(32'h7fffffff, 32'h7fffffff, 32'h80000000, -1, 0, 0, 1'b0);
        // repeated minimum rows: singular
        add_row(32'h80000000, 32'h80000000, 32'h80000000, -1, -1, 0, 1'b0);
        add_row(32'h80000000, 32'h80000000, 32'h80000000, -1, 1, 0, 1'b0);
        add_row(32'h80000000, 32'h80000000, 32'h80000000, -1, 32'h7fffffff, 0, 1'b0);

        // random phases: no idling, heavy idling, medium, then alternating, with drains between some systems
        for (int s = 0; s < 52; s++) begin
            case (s / 13)
                0: pct = 0;
                1: pct = 77;
                2: pct = 32;
                default: pct = (s % 2) ? 0 : 77;
            endcase
            add_system(pct, (s % 13) == 0);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (row_queue.size() == 0 && !i_start && update_queue.size() == 0);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (errors == 0 && update_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (update_queue.size() != 0) report("expected updates never arrived");
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### cramer_newton_update_3x3.f
hw/rtl/cnu_pkg.sv
hw/rtl/cramer_newton_update_3x3.sv
dv/cramer_newton_update_3x3_tb.sv
